### src/nfsa_pkg.sv
// ----------------------------------------------------------------------------
// nfsa_pkg
// shared widths, codes, table entry layout and control structs for the
// next-fit slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

package nfsa_pkg;

	localparam int SLOT_COUNT_DEF = 1024;

	// one memory row holds this many slots
	localparam int ROW_W    = 32;
	localparam int ROW_BITS = 5;

	localparam int SEED_W     = 4;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int HANDLE_W   = 14;
	localparam int SLOT_OUT_W = 10;

	// request codes
	localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd2;

	typedef struct packed {
		logic              used;
		logic              local_flag;
		logic [SEED_W-1:0] seed;
	} entry_t;

	typedef entry_t [ROW_W-1:0] row_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clear;
	} mem_ctl_t;

	typedef struct packed {
		logic wr;
		logic has_free;
		logic clear;
	} fm_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_EVAL,
		S_FILL,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

### src/nfsa_if.sv
// ----------------------------------------------------------------------------
// nfsa request and response channels
// valid/ready channels carrying one request or one result per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface nfsa_req_if;
	import nfsa_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [HANDLE_W-1:0] handle_in;

	modport source(output valid, op, handle_in, input ready);
	modport sink(input valid, op, handle_in, output ready);
endinterface

interface nfsa_rsp_if;
	import nfsa_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [HANDLE_W-1:0]   handle_out;
	logic [SLOT_OUT_W-1:0] slot_out;

	modport source(output valid, status, handle_out, slot_out, input ready);
	modport sink(input valid, status, handle_out, slot_out, output ready);
endinterface

`default_nettype wire

### src/nfsa_row_mem.sv
// ----------------------------------------------------------------------------
// nfsa_row_mem
// slot table memory, one row of slot entries per word, with per-row valid
// bits so that reset and clear empty the table at once
// ----------------------------------------------------------------------------
`default_nettype none

module nfsa_row_mem #(
	parameter int ROWS      = 32,
	parameter int ROW_IDX_W = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  nfsa_pkg::mem_ctl_t     ctl,
	input  logic [ROW_IDX_W-1:0]   rd_row,
	input  logic [ROW_IDX_W-1:0]   wr_row,
	input  nfsa_pkg::row_t         wr_data,
	output nfsa_pkg::row_t         rd_data
);
	import nfsa_pkg::*;

	row_t            mem [ROWS];
	row_t            rd_data_q;
	logic [ROWS-1:0] row_valid_q;
	logic            rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_row] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data_q <= mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (ctl.clear) begin
				row_valid_q <= '0;
			end else if (ctl.wr) begin
				row_valid_q[wr_row] <= 1'b1;
			end
			if (ctl.rd) begin
				rd_valid_q <= row_valid_q[rd_row];
			end
		end
	end

	// a row never written since reset or clear reads as empty
	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

### src/nfsa_free_map.sv
// ----------------------------------------------------------------------------
// nfsa_free_map
// one bit per memory row telling whether the row has a free slot, and a
// registered circular search for the next row with room
// ----------------------------------------------------------------------------
`default_nettype none

module nfsa_free_map #(
	parameter int ROWS      = 32,
	parameter int ROW_IDX_W = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nfsa_pkg::fm_ctl_t    ctl,
	input  logic [ROW_IDX_W-1:0] upd_row,
	input  logic [ROW_IDX_W-1:0] start_row,
	output logic                 found_any,
	output logic [ROW_IDX_W-1:0] found_row
);
	import nfsa_pkg::*;

	logic [ROWS-1:0]      row_free_q;
	logic                 found_any_q;
	logic [ROW_IDX_W-1:0] found_row_q;
	logic                 hi_any;
	logic                 lo_any;
	logic [ROW_IDX_W-1:0] hi_idx;
	logic [ROW_IDX_W-1:0] lo_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_free_q <= '1;
		end else if (ctl.clear) begin
			row_free_q <= '1;
		end else if (ctl.wr) begin
			row_free_q[upd_row] <= ctl.has_free;
		end
	end

	// first free row after start_row, else the first free row from row 0
	always_comb begin
		hi_any = 1'b0;
		lo_any = 1'b0;
		hi_idx = '0;
		lo_idx = '0;
		for (int r = ROWS - 1; r >= 0; r--) begin
			if (row_free_q[r]) begin
				lo_any = 1'b1;
				lo_idx = ROW_IDX_W'(r);
				if (r > int'(start_row)) begin
					hi_any = 1'b1;
					hi_idx = ROW_IDX_W'(r);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_any_q <= 1'b0;
		end else begin
			found_any_q <= lo_any;
		end
	end

	always_ff @(posedge clk) begin
		found_row_q <= hi_any ? hi_idx : lo_idx;
	end

	assign found_any = found_any_q;
	assign found_row = found_row_q;

endmodule

`default_nettype wire

### src/next_fit_slot_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_slot_allocator
// slot table serving create, delete and clear requests with next-fit search
// and 4-bit generation seeds folded into the returned handles
// ----------------------------------------------------------------------------
// usage
//   req  (sink)  : op and handle_in, one request per transaction
//   rsp  (source): status, handle_out and slot_out, one result per request
//   one request is in flight at a time; req.ready is high while idle
//   a request passes through the divide, evaluate and done states, with a
//   fill state before done when a create finds no room at or after the start
//   point in its row and reads a second row; the steps follow the
//   read-modify-write of the row memory (one registered read per row) and the handle divide
//   rsp.valid rises when the done state loads the output register
//   the result sits in an output register, so the next request is accepted
//   and worked on while rsp is stalled; only the handoff of that next result
//   waits for rsp.ready
//   reset empties the table at once through per-row valid bits: no clearing
//   pass, requests are taken from the first cycle after reset
//   clear does the same and returns status ok
// ----------------------------------------------------------------------------
`default_nettype none

module next_fit_slot_allocator #(
	parameter int SLOT_COUNT = nfsa_pkg::SLOT_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	nfsa_req_if.sink   req,
	nfsa_rsp_if.source rsp
);
	import nfsa_pkg::*;

	localparam int SLOT_W    = $clog2(SLOT_COUNT);
	localparam int ROWS      = (SLOT_COUNT + ROW_W - 1) / ROW_W;
	localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PROD_W    = 2 * HANDLE_W;
	// floor reciprocal: quotient estimate is exact or one short
	localparam int RECIP     = (1 << HANDLE_W) / SLOT_COUNT;

	// lowest set bit of a row mask, with a hit flag on top
	function automatic logic [ROW_BITS:0] find_low(input logic [ROW_W-1:0] m);
		logic [ROW_BITS:0] r;
		r = '0;
		for (int b = ROW_W - 1; b >= 0; b--) begin
			if (m[b]) begin
				r = {1'b1, ROW_BITS'(b)};
			end
		end
		return r;
	endfunction

	// slots of a row that exist (last row may be partial)
	function automatic logic [ROW_W-1:0] row_mask(input logic [ROW_IDX_W-1:0] row);
		logic [ROW_W-1:0] m;
		for (int b = 0; b < ROW_W; b++) begin
			m[b] = (int'(row) * ROW_W + b) < SLOT_COUNT;
		end
		return m;
	endfunction

	// control and request registers
	state_t               state_q, state_d;
	logic [OP_W-1:0]      op_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic [PROD_W-1:0]    prod_q;
	logic [SLOT_W-1:0]    search_start_q;
	logic [ROW_IDX_W-1:0] cur_row_q;

	// decoded delete handle
	logic [SLOT_W-1:0]    del_slot_q;
	logic [SEED_W-1:0]    del_seed_q;
	logic                 del_seed_ok_q;

	// result waiting for the output register
	logic [STATUS_W-1:0]  res_status_q;
	logic [SLOT_W-1:0]    res_slot_q;
	logic [SEED_W-1:0]    res_seed_q;
	logic                 res_new_q;

	// output register
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [HANDLE_W-1:0]   out_handle_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;

	// handle divide by slot count
	logic [HANDLE_W-1:0]  q_est;
	logic [PROD_W-1:0]    qn;
	logic [PROD_W-1:0]    rem_est;
	logic [PROD_W-1:0]    rem_fix;
	logic [HANDLE_W-1:0]  q_fix;
	logic [SLOT_W-1:0]    div_slot;
	logic [ROW_IDX_W-1:0] div_row;

	// search start split into row and offset
	logic [31:0]          start_ext;
	logic [ROW_IDX_W-1:0] start_row;
	logic [ROW_BITS-1:0]  start_off;
	logic [31:0]          del_ext;
	logic [ROW_BITS-1:0]  del_bit;

	// memory and free map
	mem_ctl_t             mem_ctl;
	fm_ctl_t              fm_ctl;
	logic [ROW_IDX_W-1:0] rd_row;
	row_t                 wr_data;
	row_t                 rd_data;
	logic                 found_any;
	logic [ROW_IDX_W-1:0] found_row;

	// row evaluation
	logic [ROW_W-1:0]     cur_mask;
	logic [ROW_W-1:0]     free_bits;
	logic [ROW_W-1:0]     off_mask;
	logic [ROW_W-1:0]     sel_mask;
	logic [ROW_W-1:0]     new_free;
	logic                 sel_hit;
	logic [ROW_BITS-1:0]  sel_idx;
	logic [SLOT_W-1:0]    sel_slot;
	logic [SLOT_W:0]      slot_inc;
	logic [SLOT_W-1:0]    start_next;
	entry_t               del_entry;
	logic                 del_ok;
	logic                 take;

	// evaluation outcome
	logic                 ev_done;
	logic [STATUS_W-1:0]  ev_status;
	logic [SLOT_W-1:0]    ev_slot;
	logic [SEED_W-1:0]    ev_seed;
	logic                 ev_new;
	logic                 start_upd;
	logic                 start_clr;
	logic                 load_out;
	logic [PROD_W-1:0]    hsum;

	nfsa_row_mem #(
		.ROWS      (ROWS),
		.ROW_IDX_W (ROW_IDX_W)
	) u_row_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.rd_row  (rd_row),
		.wr_row  (cur_row_q),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	nfsa_free_map #(
		.ROWS      (ROWS),
		.ROW_IDX_W (ROW_IDX_W)
	) u_free_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (fm_ctl),
		.upd_row   (cur_row_q),
		.start_row (start_row),
		.found_any (found_any),
		.found_row (found_row)
	);

	assign req.ready = (state_q == S_IDLE);

	// remainder/quotient from the registered reciprocal product, one correction
	always_comb begin
		q_est   = prod_q[PROD_W-1:HANDLE_W];
		qn      = PROD_W'(q_est) * PROD_W'(SLOT_COUNT);
		rem_est = PROD_W'(handle_q) - qn;
		if (rem_est >= PROD_W'(SLOT_COUNT)) begin
			rem_fix = rem_est - PROD_W'(SLOT_COUNT);
			q_fix   = q_est + HANDLE_W'(1);
		end else begin
			rem_fix = rem_est;
			q_fix   = q_est;
		end
		div_slot = SLOT_W'(rem_fix);
		div_row  = ROW_IDX_W'(div_slot >> ROW_BITS);
	end

	assign start_ext = 32'(search_start_q);
	assign start_row = ROW_IDX_W'(search_start_q >> ROW_BITS);
	assign start_off = start_ext[ROW_BITS-1:0];
	assign del_ext   = 32'(del_slot_q);
	assign del_bit   = del_ext[ROW_BITS-1:0];

	// row search, next state and table update
	always_comb begin
		cur_mask = row_mask(cur_row_q);
		for (int b = 0; b < ROW_W; b++) begin
			free_bits[b] = !rd_data[b].used && cur_mask[b];
			off_mask[b]  = (b >= int'(start_off));
		end
		// first read of a create only looks at or after the start offset
		sel_mask = (state_q == S_EVAL) ? (free_bits & off_mask) : free_bits;
		{sel_hit, sel_idx} = find_low(sel_mask);
		sel_slot   = SLOT_W'({cur_row_q, sel_idx});
		slot_inc   = (SLOT_W + 1)'(sel_slot) + (SLOT_W + 1)'(1);
		start_next = (slot_inc == (SLOT_W + 1)'(SLOT_COUNT)) ? '0 : SLOT_W'(slot_inc);

		del_entry = rd_data[del_bit];
		del_ok    = del_entry.used && del_entry.local_flag && del_seed_ok_q
			&& (del_entry.seed == del_seed_q);

		state_d   = state_q;
		mem_ctl   = '0;
		fm_ctl    = '0;
		rd_row    = start_row;
		wr_data   = rd_data;
		take      = 1'b0;
		ev_done   = 1'b0;
		ev_status = ST_OK;
		ev_slot   = '0;
		ev_seed   = '0;
		ev_new    = 1'b0;
		start_upd = 1'b0;
		start_clr = 1'b0;
		load_out  = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				mem_ctl.rd = 1'b1;
				rd_row     = (op_q == OP_DELETE) ? div_row : start_row;
				state_d    = S_EVAL;
			end
			S_EVAL: begin
				unique case (op_q)
					OP_CREATE: begin
						if (sel_hit) begin
							take = 1'b1;
						end else if (found_any) begin
							// wrap to the next row that has room
							mem_ctl.rd = 1'b1;
							rd_row     = found_row;
							state_d    = S_FILL;
						end else begin
							ev_done   = 1'b1;
							ev_status = ST_FULL;
						end
					end
					OP_DELETE: begin
						ev_done = 1'b1;
						if (del_ok) begin
							wr_data[del_bit].used = 1'b0;
							mem_ctl.wr = 1'b1;
							fm_ctl.wr  = 1'b1;
							ev_slot    = del_slot_q;
						end else begin
							ev_status = ST_BAD_HANDLE;
						end
					end
					OP_CLEAR: begin
						ev_done       = 1'b1;
						mem_ctl.clear = 1'b1;
						fm_ctl.clear  = 1'b1;
						start_clr     = 1'b1;
					end
					default: begin
						ev_done = 1'b1;
					end
				endcase
			end
			S_FILL: begin
				take = 1'b1;
			end
			S_DONE: begin
				load_out = !out_valid_q || rsp.ready;
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// claim the selected slot and bump its seed
		if (take) begin
			wr_data[sel_idx].used       = 1'b1;
			wr_data[sel_idx].local_flag = 1'b1;
			wr_data[sel_idx].seed       = rd_data[sel_idx].seed + SEED_W'(1);
			mem_ctl.wr = 1'b1;
			fm_ctl.wr  = 1'b1;
			ev_done    = 1'b1;
			ev_slot    = sel_slot;
			ev_seed    = rd_data[sel_idx].seed + SEED_W'(1);
			ev_new     = 1'b1;
			start_upd  = 1'b1;
		end

		if (ev_done) begin
			state_d = S_DONE;
		end

		for (int b = 0; b < ROW_W; b++) begin
			new_free[b] = !wr_data[b].used && cur_mask[b];
		end
		fm_ctl.has_free = |new_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			search_start_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_clr) begin
				search_start_q <= '0;
			end else if (start_upd) begin
				search_start_q <= start_next;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// seed times slot count plus slot, low bits kept
	assign hsum = PROD_W'(res_seed_q) * PROD_W'(SLOT_COUNT) + PROD_W'(res_slot_q);

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q     <= req.op;
			handle_q <= req.handle_in;
			prod_q   <= PROD_W'(req.handle_in) * PROD_W'(RECIP);
		end
		if (state_q == S_DIV) begin
			del_slot_q    <= div_slot;
			del_seed_q    <= q_fix[SEED_W-1:0];
			del_seed_ok_q <= ((q_fix >> SEED_W) == '0);
		end
		if (mem_ctl.rd) begin
			cur_row_q <= rd_row;
		end
		if (ev_done) begin
			res_status_q <= ev_status;
			res_slot_q   <= ev_slot;
			res_seed_q   <= ev_seed;
			res_new_q    <= ev_new;
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_handle_q <= res_new_q ? hsum[HANDLE_W-1:0] : '0;
			out_slot_q   <= SLOT_OUT_W'(res_slot_q);
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.handle_out = out_handle_q;
	assign rsp.slot_out   = out_slot_q;

`ifndef SYNTHESIS
	// the free map sent the search to this row, so it must hold a free slot
	a_fill_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> sel_hit)
		else $error("second row read without a free slot");

	// a free slot in the start row must also show in the free map
	a_map_agrees: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && op_q == OP_CREATE && sel_hit) |-> found_any)
		else $error("free map lost a row with room");

	a_start_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(search_start_q) < SLOT_COUNT)
		else $error("search start beyond table");

	// a finished result waits while the output register is stalled
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !rsp.ready) |=> (state_q == S_DONE))
		else $error("result handed off into a stalled output register");
`endif

endmodule

`default_nettype wire
